// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: src/bmhq_pkg.sv
`default_nettype none

package bmhq_pkg;

	// Heap geometry and field widths.
	localparam int ADDR_W   = 6;
	localparam int CAPACITY = 2 ** ADDR_W;
	localparam int COUNT_W  = ADDR_W + 1;
	localparam int VERTEX_W = 8;
	localparam int KEY_W    = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Datapath command codes.
	localparam int CMD_W = 4;
	localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
	localparam logic [CMD_W-1:0] CMD_ENQ_START = 4'd1;
	localparam logic [CMD_W-1:0] CMD_ENQ_FULL  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DEQ_START = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DEQ_EMPTY = 4'd4;
	localparam logic [CMD_W-1:0] CMD_QRY_START = 4'd5;
	localparam logic [CMD_W-1:0] CMD_NOP_START = 4'd6;
	localparam logic [CMD_W-1:0] CMD_UP_PLACE  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_UP_READ   = 4'd8;
	localparam logic [CMD_W-1:0] CMD_UP_STEP   = 4'd9;
	localparam logic [CMD_W-1:0] CMD_DEQ_TAKE  = 4'd10;
	localparam logic [CMD_W-1:0] CMD_DN_PLACE  = 4'd11;
	localparam logic [CMD_W-1:0] CMD_DN_READ   = 4'd12;
	localparam logic [CMD_W-1:0] CMD_DN_STEP   = 4'd13;
	localparam logic [CMD_W-1:0] CMD_SCAN_READ = 4'd14;
	localparam logic [CMD_W-1:0] CMD_SCAN_STEP = 4'd15;

	// One heap slot.
	typedef struct packed {
		logic [VERTEX_W-1:0]    vertex;
		logic signed [KEY_W-1:0] key;
	} entry_t;

	// Controller to datapath.
	typedef struct packed {
		logic [CMD_W-1:0] code;
		logic             result_load;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic last_one;
		logic at_root;
		logic no_left;
		logic scan_end;
		logic up_stop;
		logic dn_stop;
		logic hit;
	} stat_t;

endpackage

`default_nettype wire

// File: src/bmhq_ctrl.sv
`default_nettype none

module bmhq_ctrl (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           req_valid,
	output logic                          req_ready,
	input  wire  [bmhq_pkg::OP_W-1:0]     operation,
	output logic                          rsp_valid,
	input  wire                           rsp_ready,
	input  bmhq_pkg::stat_t               stat,
	output bmhq_pkg::cmd_t                cmd
);

	localparam int STATE_W = 4;
	localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
	localparam logic [STATE_W-1:0] S_UP_RD  = 4'd1;
	localparam logic [STATE_W-1:0] S_UP_CMP = 4'd2;
	localparam logic [STATE_W-1:0] S_DEQ    = 4'd3;
	localparam logic [STATE_W-1:0] S_DN_RD  = 4'd4;
	localparam logic [STATE_W-1:0] S_DN_CMP = 4'd5;
	localparam logic [STATE_W-1:0] S_QRD    = 4'd6;
	localparam logic [STATE_W-1:0] S_QCMP   = 4'd7;
	localparam logic [STATE_W-1:0] S_DONE   = 4'd8;

	logic [STATE_W-1:0] state_q;
	logic [STATE_W-1:0] state_nxt;
	logic               rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and command decode.
	always_comb begin
		state_nxt        = state_q;
		cmd.code         = bmhq_pkg::CMD_NONE;
		cmd.result_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (operation)
						bmhq_pkg::OP_ENQUEUE: begin
							if (stat.full) begin
								cmd.code  = bmhq_pkg::CMD_ENQ_FULL;
								state_nxt = S_DONE;
							end else begin
								cmd.code  = bmhq_pkg::CMD_ENQ_START;
								state_nxt = S_UP_RD;
							end
						end
						bmhq_pkg::OP_DEQUEUE: begin
							if (stat.empty) begin
								cmd.code  = bmhq_pkg::CMD_DEQ_EMPTY;
								state_nxt = S_DONE;
							end else begin
								cmd.code  = bmhq_pkg::CMD_DEQ_START;
								state_nxt = S_DEQ;
							end
						end
						bmhq_pkg::OP_QUERY: begin
							cmd.code  = bmhq_pkg::CMD_QRY_START;
							state_nxt = S_QRD;
						end
						default: begin
							cmd.code  = bmhq_pkg::CMD_NOP_START;
							state_nxt = S_DONE;
						end
					endcase
				end
			end
			S_UP_RD: begin
				if (stat.at_root) begin
					cmd.code  = bmhq_pkg::CMD_UP_PLACE;
					state_nxt = S_DONE;
				end else begin
					cmd.code  = bmhq_pkg::CMD_UP_READ;
					state_nxt = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				cmd.code  = bmhq_pkg::CMD_UP_STEP;
				state_nxt = stat.up_stop ? S_DONE : S_UP_RD;
			end
			S_DEQ: begin
				cmd.code  = bmhq_pkg::CMD_DEQ_TAKE;
				state_nxt = stat.last_one ? S_DONE : S_DN_RD;
			end
			S_DN_RD: begin
				if (stat.no_left) begin
					cmd.code  = bmhq_pkg::CMD_DN_PLACE;
					state_nxt = S_DONE;
				end else begin
					cmd.code  = bmhq_pkg::CMD_DN_READ;
					state_nxt = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				cmd.code  = bmhq_pkg::CMD_DN_STEP;
				state_nxt = stat.dn_stop ? S_DONE : S_DN_RD;
			end
			S_QRD: begin
				if (stat.scan_end) begin
					state_nxt = S_DONE;
				end else begin
					cmd.code  = bmhq_pkg::CMD_SCAN_READ;
					state_nxt = S_QCMP;
				end
			end
			S_QCMP: begin
				cmd.code  = bmhq_pkg::CMD_SCAN_STEP;
				state_nxt = stat.hit ? S_DONE : S_QRD;
			end
			S_DONE: begin
				// Hand the result to the output register once it is free.
				if (!rsp_valid_q || rsp_ready) begin
					cmd.result_load = 1'b1;
					state_nxt       = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.result_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/bmhq_datapath.sv
`default_nettype none

module bmhq_datapath (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  [bmhq_pkg::VERTEX_W-1:0]       vertex,
	input  wire  [bmhq_pkg::KEY_W-1:0]          key,
	input  bmhq_pkg::cmd_t                      cmd,
	output bmhq_pkg::stat_t                     stat,
	output logic [bmhq_pkg::STATUS_W-1:0]       status,
	output logic [bmhq_pkg::VERTEX_W-1:0]       min_vertex,
	output logic                                found,
	output logic                                now_empty,
	output logic [bmhq_pkg::COUNT_W-1:0]        entry_count
);

	localparam int AW = bmhq_pkg::ADDR_W;
	localparam int CW = bmhq_pkg::COUNT_W;

	// Heap storage: one write port, two registered read ports.
	bmhq_pkg::entry_t heap_mem [bmhq_pkg::CAPACITY];

	bmhq_pkg::entry_t               item_q;
	bmhq_pkg::entry_t               rd_a_q;
	bmhq_pkg::entry_t               rd_b_q;
	logic [AW-1:0]                  pos_q;
	logic [CW-1:0]                  fill_q;
	logic [CW-1:0]                  scan_q;
	logic [bmhq_pkg::STATUS_W-1:0]  res_status_q;
	logic [bmhq_pkg::VERTEX_W-1:0]  res_min_q;
	logic                           res_found_q;
	logic [bmhq_pkg::STATUS_W-1:0]  status_q;
	logic [bmhq_pkg::VERTEX_W-1:0]  min_vertex_q;
	logic                           found_q;
	logic                           now_empty_q;
	logic [CW-1:0]                  entry_count_q;

	logic [AW-1:0]                  pos_dec;
	logic [AW-1:0]                  parent;
	logic [CW-1:0]                  left_idx;
	logic [CW:0]                    right_idx;
	logic [CW:0]                    fill_ext;
	logic [CW:0]                    scan_next;
	logic                           left_ok;
	logic                           right_ok;
	logic                           left_less;
	logic                           right_less;
	logic signed [bmhq_pkg::KEY_W-1:0] best_key;
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr_a;
	logic [AW-1:0]                  rd_addr_b;
	logic                           wr_en;
	bmhq_pkg::entry_t               wr_data;

	// Tree neighbors of the current position.
	assign pos_dec   = pos_q - AW'(1);
	assign parent    = {1'b0, pos_dec[AW-1:1]};
	assign left_idx  = {pos_q, 1'b1};
	assign right_idx = {1'b0, pos_q, 1'b0} + (CW+1)'(2);
	assign fill_ext  = {1'b0, fill_q};
	assign scan_next = {1'b0, scan_q} + (CW+1)'(1);
	assign left_ok   = left_idx < fill_q;
	assign right_ok  = right_idx < fill_ext;

	// Sift-down child selection; the parent stays on a tie, the left child wins a tie.
	assign left_less  = left_ok && ($signed(rd_a_q.key) < $signed(item_q.key));
	assign best_key   = left_less ? rd_a_q.key : item_q.key;
	assign right_less = right_ok && ($signed(rd_b_q.key) < $signed(best_key));

	// Status toward the controller.
	always_comb begin
		stat.full     = (fill_q == CW'(bmhq_pkg::CAPACITY));
		stat.empty    = (fill_q == '0);
		stat.last_one = (fill_q == CW'(1));
		stat.at_root  = (pos_q == '0);
		stat.no_left  = !left_ok;
		stat.scan_end = (scan_q >= fill_q);
		stat.up_stop  = !($signed(item_q.key) < $signed(rd_a_q.key));
		stat.dn_stop  = !left_less && !right_less;
		stat.hit      = (rd_a_q.vertex == item_q.vertex) ||
			((scan_next < fill_ext) && (rd_b_q.vertex == item_q.vertex));
	end

	// Memory address and write selection.
	always_comb begin
		rd_en     = 1'b0;
		rd_addr_a = '0;
		rd_addr_b = '0;
		wr_en     = 1'b0;
		wr_data   = item_q;
		case (cmd.code)
			bmhq_pkg::CMD_DEQ_START: begin
				rd_en     = 1'b1;
				rd_addr_b = AW'(fill_q - CW'(1));
			end
			bmhq_pkg::CMD_UP_READ: begin
				rd_en     = 1'b1;
				rd_addr_a = parent;
			end
			bmhq_pkg::CMD_DN_READ: begin
				rd_en     = 1'b1;
				rd_addr_a = left_idx[AW-1:0];
				rd_addr_b = right_idx[AW-1:0];
			end
			bmhq_pkg::CMD_SCAN_READ: begin
				rd_en     = 1'b1;
				rd_addr_a = scan_q[AW-1:0];
				rd_addr_b = scan_next[AW-1:0];
			end
			bmhq_pkg::CMD_UP_PLACE, bmhq_pkg::CMD_DN_PLACE: begin
				wr_en = 1'b1;
			end
			bmhq_pkg::CMD_UP_STEP: begin
				wr_en   = 1'b1;
				wr_data = stat.up_stop ? item_q : rd_a_q;
			end
			bmhq_pkg::CMD_DN_STEP: begin
				wr_en = 1'b1;
				if (right_less) begin
					wr_data = rd_b_q;
				end else if (left_less) begin
					wr_data = rd_a_q;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Heap memory.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem[pos_q] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= heap_mem[rd_addr_a];
			rd_b_q <= heap_mem[rd_addr_b];
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.code == bmhq_pkg::CMD_ENQ_START) begin
			fill_q <= fill_q + CW'(1);
		end else if (cmd.code == bmhq_pkg::CMD_DEQ_TAKE) begin
			fill_q <= fill_q - CW'(1);
		end
	end

	// The root was read on port A together with the last slot on port B.
	function automatic logic [bmhq_pkg::VERTEX_W-1:0] heap_root_vertex(
		input bmhq_pkg::entry_t e);
		return e.vertex;
	endfunction

	// Moving entry, position, scan index and pending result fields.
	always_ff @(posedge clk) begin
		case (cmd.code)
			bmhq_pkg::CMD_ENQ_START: begin
				item_q.vertex <= vertex;
				item_q.key    <= key;
				pos_q         <= fill_q[AW-1:0];
				res_status_q  <= bmhq_pkg::ST_OK;
				res_min_q     <= '0;
				res_found_q   <= 1'b0;
			end
			bmhq_pkg::CMD_ENQ_FULL: begin
				res_status_q <= bmhq_pkg::ST_FULL;
				res_min_q    <= '0;
				res_found_q  <= 1'b0;
			end
			bmhq_pkg::CMD_DEQ_START, bmhq_pkg::CMD_NOP_START: begin
				res_status_q <= bmhq_pkg::ST_OK;
				res_min_q    <= '0;
				res_found_q  <= 1'b0;
			end
			bmhq_pkg::CMD_DEQ_EMPTY: begin
				res_status_q <= bmhq_pkg::ST_EMPTY;
				res_min_q    <= '0;
				res_found_q  <= 1'b0;
			end
			bmhq_pkg::CMD_QRY_START: begin
				item_q.vertex <= vertex;
				scan_q        <= '0;
				res_status_q  <= bmhq_pkg::ST_OK;
				res_min_q     <= '0;
				res_found_q   <= 1'b0;
			end
			bmhq_pkg::CMD_DEQ_TAKE: begin
				res_min_q <= heap_root_vertex(rd_a_q);
				item_q    <= rd_b_q;
				pos_q     <= '0;
			end
			bmhq_pkg::CMD_UP_STEP: begin
				if (!stat.up_stop) begin
					pos_q <= parent;
				end
			end
			bmhq_pkg::CMD_DN_STEP: begin
				if (right_less) begin
					pos_q <= right_idx[AW-1:0];
				end else if (left_less) begin
					pos_q <= left_idx[AW-1:0];
				end
			end
			bmhq_pkg::CMD_SCAN_STEP: begin
				if (stat.hit) begin
					res_found_q <= 1'b1;
				end
				scan_q <= scan_q + CW'(2);
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			status_q      <= res_status_q;
			min_vertex_q  <= res_min_q;
			found_q       <= res_found_q;
			now_empty_q   <= (fill_q == '0);
			entry_count_q <= fill_q;
		end
	end

	assign status      = status_q;
	assign min_vertex  = min_vertex_q;
	assign found       = found_q;
	assign now_empty   = now_empty_q;
	assign entry_count = entry_count_q;

endmodule

`default_nettype wire

// File: src/binary_min_heap_queue.sv
// Binary min-heap priority queue of 64 (vertex, signed key) entries in one two-read, one-write
// memory. Each request transaction is an enqueue, a dequeue of the smallest key or a membership
// query, and yields exactly one response transaction with status, removed vertex, found flag,
// empty flag and entry count. One request is worked on at a time; a new request is taken while
// the previous response still waits. Each heap level is a registered read, then a compare and
// write back; an enqueue climbs toward the root, a dequeue descends toward the leaves, and a
// query scans the entries two per read. Ties keep the parent in place and favor the left child.
`default_nettype none

module binary_min_heap_queue (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 req_valid,
	output logic                                req_ready,
	input  wire  [bmhq_pkg::OP_W-1:0]           operation,
	input  wire  [bmhq_pkg::VERTEX_W-1:0]       vertex,
	input  wire  [bmhq_pkg::KEY_W-1:0]          key,
	output logic                                rsp_valid,
	input  wire                                 rsp_ready,
	output logic [bmhq_pkg::STATUS_W-1:0]       status,
	output logic [bmhq_pkg::VERTEX_W-1:0]       min_vertex,
	output logic                                found,
	output logic                                now_empty,
	output logic [bmhq_pkg::COUNT_W-1:0]        entry_count
);

	bmhq_pkg::cmd_t  cmd;
	bmhq_pkg::stat_t stat;

	// Sequencer.
	bmhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.operation (operation),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Heap memory, compare logic and result registers.
	bmhq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex      (vertex),
		.key         (key),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.min_vertex  (min_vertex),
		.found       (found),
		.now_empty   (now_empty),
		.entry_count (entry_count)
	);

endmodule

`default_nettype wire

// File: src/bmhq_checker.sv
`default_nettype none
`include "assert_macros.svh"

module bmhq_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               rsp_valid,
	input wire                               rsp_ready,
	input wire [bmhq_pkg::STATUS_W-1:0]      status,
	input wire [bmhq_pkg::VERTEX_W-1:0]      min_vertex,
	input wire                               found,
	input wire                               now_empty,
	input wire [bmhq_pkg::COUNT_W-1:0]       entry_count
);

	// The count never exceeds the capacity, and the empty flag agrees with it.
	`ASSERT_IMPLIES(a_count_range, clk, arst_n, rsp_valid, (entry_count <= bmhq_pkg::COUNT_W'(bmhq_pkg::CAPACITY)) && (now_empty == (entry_count == '0)))

	// A dropped enqueue only happens on a full heap.
	`ASSERT_IMPLIES(a_full_status, clk, arst_n, rsp_valid && (status == bmhq_pkg::ST_FULL), entry_count == bmhq_pkg::COUNT_W'(bmhq_pkg::CAPACITY))

	// A refused dequeue leaves an empty heap and removes nothing.
	`ASSERT_IMPLIES(a_empty_status, clk, arst_n, rsp_valid && (status == bmhq_pkg::ST_EMPTY), now_empty && (min_vertex == '0) && !found)

	// A hit needs a nonempty heap and an ok status.
	`ASSERT_IMPLIES(a_found_nonempty, clk, arst_n, rsp_valid && found, !now_empty && (status == bmhq_pkg::ST_OK))

	// A stalled response transaction holds its payload.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(min_vertex) && $stable(found) && $stable(entry_count))

endmodule

bind binary_min_heap_queue bmhq_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.status      (status),
	.min_vertex  (min_vertex),
	.found       (found),
	.now_empty   (now_empty),
	.entry_count (entry_count)
);

`default_nettype wire
